[sv/e2q_pkg.sv]
// shared types, constants and tables for the euler to quaternion pipeline
// used by every module of the block, no dependencies

package e2q_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int CORDIC_STAGES   = 16;

  localparam logic [31:0] PIQ         = 32'd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  // cosine and sine of one half angle, q2.30
  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
  } sincos_t;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000007; 28: t = 32'h00000003; 29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return $signed({2'b00, t});
  endfunction

endpackage

[sv/euler_to_quaternion.sv]
// top level of the zyx euler angle to unit quaternion pipeline
// depends on e2q_pkg, e2q_phase, e2q_cordic, e2q_combine

// Takes one set of roll, pitch and yaw angles every cycle (busy stays low)
// and delivers the quaternion with done high for one cycle, after the
// phase stages, the unrolled cordic stages and the product stages. The
// receiver cannot stall; results are never held back.

module euler_to_quaternion #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS,
  parameter int OUT_FRAC_BITS   = e2q_pkg::OUT_FRAC_BITS,
  parameter int CORDIC_STAGES   = e2q_pkg::CORDIC_STAGES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  e2q_pkg::angles_t angles,
  output logic            done,
  output e2q_pkg::quat_t  quat
);

  localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int LAT = NS + 7;

  logic signed [33:0] zr, zp, zy;
  logic fr, fp, fy;
  e2q_pkg::sincos_t scr, scp, scy;
  logic [LAT-1:0] vld;

  assign busy = 1'b0;

  e2q_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ph_r
    (.clk, .angle(angles.roll_deg), .zrad(zr), .flip(fr));
  e2q_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ph_p
    (.clk, .angle(angles.pitch_deg), .zrad(zp), .flip(fp));
  e2q_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ph_y
    (.clk, .angle(angles.yaw_deg), .zrad(zy), .flip(fy));

  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_co_r (.clk, .zin(zr), .flip(fr), .sc(scr));
  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_co_p (.clk, .zin(zp), .flip(fp), .sc(scp));
  e2q_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_co_y (.clk, .zin(zy), .flip(fy), .sc(scy));

  e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb
    (.clk, .r(scr), .p(scp), .y(scy), .q(quat));

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

  // every transfer in gives one result with done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start, LAT)) else $error("spurious result");
  a_saturated_w: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(quat.quat_w) <= 16'sd16384 || OUT_FRAC_BITS > 14))
    else $error("w out of range");

endmodule

[sv/e2q_phase.sv]
// angle to q2.30 radians of the half angle with half-turn fold, three stages
// depends on e2q_pkg

module e2q_phase #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic signed [15:0] angle,
  output logic signed [33:0] zrad,
  output logic               flip
);

  // phase = round(mag * K / 720) with K = 2^(32 - frac bits), split as
  // mag*Q + round(mag*R / 720) where K = 720*Q + R
  localparam logic [63:0] K = 64'd1 << (32 - ANGLE_FRAC_BITS);
  localparam logic [63:0] Q = K / 64'd720;
  localparam logic [63:0] R = K - Q * 64'd720;
  // floor(v / 1440) as (v * M) >> 37, exact for v below 2^26
  localparam logic [63:0] M = ((64'd1 << 37) + 64'd1439) / 64'd1440;

  // stage 1: magnitude, integer part and remainder numerator
  logic [15:0] mag;
  logic [31:0] base;
  logic [26:0] v;
  logic        neg1;
  logic [31:0] base1;
  logic [26:0] v1;

  assign mag  = angle[15] ? 16'(-angle) : 16'(angle);
  assign base = 32'(48'(mag) * 48'(Q));
  assign v    = 27'(mag) * 27'(R) * 27'd2 + 27'd720;

  always_ff @(posedge clk) begin
    neg1  <= angle[15];
    base1 <= base;
    v1    <= v;
  end

  // stage 2: finish quotient, sign, fold
  logic [63:0] prod;
  logic [31:0] p;
  logic [31:0] ph;
  logic        fl;
  logic [31:0] phf;
  logic [31:0] rmag2;
  logic        rneg2;
  logic        flip2;

  always_comb begin
    prod = 64'(v1) * M;
    p    = base1 + 32'(prod >> 37);
    ph   = neg1 ? 32'(-p) : p;
    fl   = ph[31] ^ ph[30];
    phf  = fl ? {~ph[31], ph[30:0]} : ph;
  end

  always_ff @(posedge clk) begin
    rneg2 <= phf[31];
    rmag2 <= phf[31] ? 32'(-phf) : phf;
    flip2 <= fl;
  end

  // stage 3: scale by pi
  logic [63:0] zp;
  logic [32:0] zm;
  assign zp = 64'(rmag2) * 64'(e2q_pkg::PIQ) + (64'd1 << 30);
  assign zm = zp[63:31];

  always_ff @(posedge clk) begin
    zrad <= rneg2 ? -$signed({1'b0, zm}) : $signed({1'b0, zm});
    flip <= flip2;
  end

endmodule

[sv/e2q_cordic.sv]
// unrolled rotation-mode cordic, one register per stage
// depends on e2q_pkg

module e2q_cordic #(
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic signed [33:0] zin,
  input  logic               flip,
  output e2q_pkg::sincos_t   sc
);

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic signed [33:0] x [N+1];
  logic signed [33:0] y [N+1];
  logic signed [33:0] z [N+1];
  logic               f [N+1];

  assign x[0] = e2q_pkg::CORDIC_GAIN;
  assign y[0] = '0;
  assign z[0] = zin;
  assign f[0] = flip;

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z[i][33]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - e2q_pkg::atan_q30(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + e2q_pkg::atan_q30(i);
      end
      f[i+1] <= f[i];
    end
  end

  always_ff @(posedge clk) begin
    sc.c <= f[N] ? -x[N] : x[N];
    sc.s <= f[N] ? -y[N] : y[N];
  end

endmodule

[sv/e2q_combine.sv]
// quaternion products, sums, rounding and saturation in three stages
// depends on e2q_pkg

module e2q_combine #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS
) (
  input  logic             clk,
  input  e2q_pkg::sincos_t r,
  input  e2q_pkg::sincos_t p,
  input  e2q_pkg::sincos_t y,
  output e2q_pkg::quat_t   q
);

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [35:0] LIM = 36'sd1 <<< OUT_FRAC_BITS;

  function automatic logic signed [33:0] m30(input logic signed [33:0] a,
                                             input logic signed [33:0] b);
    logic signed [67:0] t;
    t = 68'(a) * 68'(b) + (68'sd1 <<< 29);
    return 34'(t >>> 30);
  endfunction

  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (SH > 0) ? ((v + (36'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH) : v;
    if (t > LIM) t = LIM;
    if (t < -LIM) t = -LIM;
    return t[15:0];
  endfunction

  // stage 1: yaw-pitch products
  logic signed [33:0] cc, ss, sc, cs;
  e2q_pkg::sincos_t r1;
  always_ff @(posedge clk) begin
    cc <= m30(y.c, p.c);
    ss <= m30(y.s, p.s);
    sc <= m30(y.s, p.c);
    cs <= m30(y.c, p.s);
    r1 <= r;
  end

  // stage 2: times roll
  logic signed [33:0] a0, a1, b0, b1, c0, c1, d0, d1;
  always_ff @(posedge clk) begin
    a0 <= m30(cc, r1.c);  a1 <= m30(ss, r1.s);
    b0 <= m30(cc, r1.s);  b1 <= m30(ss, r1.c);
    c0 <= m30(sc, r1.s);  c1 <= m30(cs, r1.c);
    d0 <= m30(sc, r1.c);  d1 <= m30(cs, r1.s);
  end

  // stage 3: sums and output format
  always_ff @(posedge clk) begin
    q.quat_w <= to_out(36'(a0) + 36'(a1));
    q.quat_x <= to_out(36'(b0) - 36'(b1));
    q.quat_y <= to_out(36'(c0) + 36'(c1));
    q.quat_z <= to_out(36'(d0) - 36'(d1));
  end

endmodule

[test/euler_to_quaternion_tb.sv]
// testbench for euler_to_quaternion: drives angle sets and checks each quaternion
// against a bit-exact predictor of the cordic fixed-point path; depends on e2q_pkg
`timescale 1ns / 1ps

module euler_to_quaternion_tb;

  localparam int LATENCY = e2q_pkg::CORDIC_STAGES + 7;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  e2q_pkg::angles_t angles;
  logic             done;
  e2q_pkg::quat_t   quat;

  e2q_pkg::quat_t   quat_queue[$];
  int               errors;
  bit               no_gaps;

  euler_to_quaternion i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .angles(angles),
    .done  (done),
    .quat  (quat)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL euler_to_quaternion");
    $finish;
  end

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return asr64(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint atan_entry(int i);
    longint t[32] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001,
      0, 0};
    return t[i];
  endfunction

  // cosine and sine of half the angle, q2.30
  task automatic half_angle_sincos(input logic signed [15:0] ang,
                                   output longint c, output longint s);
    longint      a, x, y, z, r, dx, dy;
    longint unsigned mag, dv, p, zm;
    logic [31:0] phase;
    bit          flip;
    a = ang;
    mag = (a < 0) ? -a : a;
    dv = 64'd720 << e2q_pkg::ANGLE_FRAC_BITS;
    p = ((mag << 32) + dv / 2) / dv;
    phase = (a < 0) ? 32'(64'd0 - p) : 32'(p);
    flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
    if (flip) phase[31] = ~phase[31];
    r = longint'($signed(phase));
    zm = (longint'(r < 0 ? -r : r) * longint'(e2q_pkg::PIQ) + (64'd1 << 30)) >> 31;
    z = (r < 0) ? -longint'(zm) : longint'(zm);
    x = e2q_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < e2q_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic [15:0] round_saturate(longint v);
    int     sh;
    longint lim, q;
    sh = 30 - e2q_pkg::OUT_FRAC_BITS;
    lim = 64'sd1 <<< e2q_pkg::OUT_FRAC_BITS;
    q = (sh != 0) ? asr64(v + (64'sd1 <<< (sh - 1)), sh) : v;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q[15:0];
  endfunction

  task automatic predict_quat(input e2q_pkg::angles_t a, output e2q_pkg::quat_t q);
    longint cr, sr, cp, sp, cy, sy, cc, ss, sycp, cysp;
    half_angle_sincos(a.roll_deg, cr, sr);
    half_angle_sincos(a.pitch_deg, cp, sp);
    half_angle_sincos(a.yaw_deg, cy, sy);
    cc = mul_q30(cy, cp);
    ss = mul_q30(sy, sp);
    sycp = mul_q30(sy, cp);
    cysp = mul_q30(cy, sp);
    q.quat_w = round_saturate(mul_q30(cc, cr) + mul_q30(ss, sr));
    q.quat_x = round_saturate(mul_q30(cc, sr) - mul_q30(ss, cr));
    q.quat_y = round_saturate(mul_q30(sycp, sr) + mul_q30(cysp, cr));
    q.quat_z = round_saturate(mul_q30(sycp, cr) - mul_q30(cysp, sr));
  endtask

  // one transfer; random idle bursts before it unless gaps are off
  task automatic send_angles(input e2q_pkg::angles_t a);
    e2q_pkg::quat_t q;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start  <= 1'b1;
    angles <= a;
    predict_quat(a, q);
    do @(posedge clk); while (busy);
    quat_queue.push_back(q);
  endtask

  // start stays high into the next item; the caller lowers it at the end
  task automatic send_xyz(int r, int p, int y);
    e2q_pkg::angles_t a;
    a.roll_deg = 16'(r); a.pitch_deg = 16'(p); a.yaw_deg = 16'(y);
    send_angles(a);
  endtask

  always @(posedge clk) begin
    e2q_pkg::quat_t q;
    if (!rst && done) begin
      if (quat_queue.size() == 0) begin
        $display("%0t unexpected result, actual %h", $time, quat);
        errors++;
      end else begin
        q = quat_queue.pop_front();
        if (quat.quat_w !== q.quat_w) begin
          $display("%0t quat_w expected %h actual %h", $time, q.quat_w, quat.quat_w);
          errors++;
        end
        if (quat.quat_x !== q.quat_x) begin
          $display("%0t quat_x expected %h actual %h", $time, q.quat_x, quat.quat_x);
          errors++;
        end
        if (quat.quat_y !== q.quat_y) begin
          $display("%0t quat_y expected %h actual %h", $time, q.quat_y, quat.quat_y);
          errors++;
        end
        if (quat.quat_z !== q.quat_z) begin
          $display("%0t quat_z expected %h actual %h", $time, q.quat_z, quat.quat_z);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    int vals[10] = '{0, 23040, -23040, 32767, -32768, 1, -1, 5760, -5760, 11520};
    foreach (vals[i]) send_xyz(vals[i], 0, 0);
    foreach (vals[i]) send_xyz(0, vals[i], 0);
    send_xyz(0, 0, 32767);
    send_xyz(0, 0, -32768);
    send_xyz(32767, -32768, 23040);
    // gimbal lock, pitch at plus and minus 90 degrees
    send_xyz(2880, 5760, -1440);
    send_xyz(-2880, -5760, 1440);
  endtask

  task automatic test_random_in_range(int n);
    for (int i = 0; i < n; i++)
      send_xyz($signed(16'($urandom_range(0, 46080) - 23040)),
               $signed(16'($urandom_range(0, 46080) - 23040)),
               $signed(16'($urandom_range(0, 46080) - 23040)));
  endtask

  task automatic test_random_full(int n);
    for (int i = 0; i < n; i++)
      send_xyz($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)));
  endtask

  initial begin
    errors = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    angles = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random_in_range(1300);
    test_random_full(400);
    no_gaps = 1'b1;
    test_random_in_range(250);
    start <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS euler_to_quaternion");
    end else begin
      $display("FAIL euler_to_quaternion");
    end
    $finish;
  end

endmodule
